/* rtl/circle_rect_proximity_engine_assert.svh */
// Assertion macros shared by the proximity engine RTL.
`ifndef CIRCLE_RECT_PROXIMITY_ENGINE_ASSERT_SVH
`define CIRCLE_RECT_PROXIMITY_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CRPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("proximity engine assertion failed");
`define CRPE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("proximity engine assertion failed");
`else
`define CRPE_ASSERT(lbl, prop)
`define CRPE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/crpe_pkg.sv */
`default_nettype none
package crpe_pkg;

  localparam int MaxWalls = 64;
  localparam int FracBits = 4;
  localparam int IdxW     = $clog2(MaxWalls);
  localparam int CntW     = IdxW + 1;

  localparam logic [13:0] DIST_MAX  = 14'd16383;
  localparam logic [12:0] RATIO_ONE = 13'd4096;
  localparam logic [7:0]  VIB_FULL  = 8'd200;

  typedef enum logic [1:0] {
    CFG_WALL_COUNT    = 2'd0,
    CFG_PLAYER_RADIUS = 2'd1,
    CFG_NEAR_DISTANCE = 2'd2,
    CFG_FAR_DISTANCE  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_EDGE_A,
    S_EDGE_B,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_VIB_SEL,
    S_DIV_WAIT,
    S_SQ1,
    S_SQ2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage
`default_nettype wire

/* rtl/crpe_iter.sv */
`default_nettype none
// Shared restoring unit: square root two bits a step, division one bit a step.
module crpe_iter (
  input  wire                    clk,
  input  wire                    rst_n,
  input  crpe_pkg::iter_ctl_t    ctl,
  input  wire  [27:0]            arg,
  input  wire  [13:0]            den,
  output crpe_pkg::iter_sts_t    sts,
  output logic [13:0]            res
);
  import crpe_pkg::*;

  logic [27:0] arg_r, arg_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [13:0] res_r, res_nxt;
  logic [13:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  iter_op_t    op_r, op_nxt;

  logic [16:0] cur, sub;
  logic [17:0] diff;

  always_comb begin
    if (op_r == OP_SQRT) begin
      cur = {rem_r[14:0], arg_r[27:26]};
      sub = {1'b0, res_r, 2'b01};
    end else begin
      cur = {rem_r[15:0], arg_r[27]};
      sub = {3'b000, den_r};
    end
    diff = {1'b0, cur} - {1'b0, sub};
  end

  always_comb begin
    arg_nxt  = arg_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    op_nxt   = op_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      arg_nxt  = arg;
      den_nxt  = den;
      op_nxt   = ctl.op;
      rem_nxt  = '0;
      res_nxt  = '0;
      cnt_nxt  = (ctl.op == OP_SQRT) ? 5'd14 : 5'd26;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      arg_nxt = (op_r == OP_SQRT) ? {arg_r[25:0], 2'b00} : {arg_r[26:0], 1'b0};
      if (!diff[17]) begin
        rem_nxt = diff[16:0];
        res_nxt = {res_r[12:0], 1'b1};
      end else begin
        rem_nxt = cur;
        res_nxt = {res_r[12:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    arg_r <= arg_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    den_r <= den_nxt;
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res      = res_r;

endmodule
`default_nettype wire

/* rtl/circle_rect_proximity_engine.sv */
// Load word: written into the wall table on acceptance, no result.
// Query word: for each of the N walls walked, a table read, then S_EDGE_A and S_EDGE_B per edge;
// then the square root of the nearest squared distance and, where needed, the ratio division.
// The square root and the ratio division share one iterative unit.
// One word at a time: in_tready is high only while idle, so each query ends before the next word.
// Synchronous active-low reset restores the register defaults; the wall table is not cleared.
`default_nettype none
`include "circle_rect_proximity_engine_assert.svh"
module circle_rect_proximity_engine (
  input  wire         clk,
  input  wire         rst_n,
  // Input words.
  input  wire         in_tvalid,
  output logic        in_tready,
  // in_tdata, low bit up: wall_slot[5:0], wall_left[14:6], wall_top[23:15],
  // wall_right[32:24], wall_bottom[41:33], point_x[54:42], point_y[67:55],
  // zero padding [79:68].
  input  wire  [79:0] in_tdata,
  // in_tuser: mode (0 loads a wall, 1 queries a point).
  input  wire         in_tuser,
  // Result words.
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_tdata, low bit up: collision[0], nearest_distance[14:1],
  // vibration_level[22:15], zero padding [23].
  output logic [23:0] out_tdata,
  // Configuration writes.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [13:0] cfg_data
);
  import crpe_pkg::*;

  // Configuration registers.
  logic [6:0]  wall_count_r;
  logic [9:0]  radius_r;
  logic [13:0] near_r;
  logic [13:0] far_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_count_r <= 7'd0;
      radius_r     <= 10'd128;
      near_r       <= 14'd160;
      far_r        <= 14'd800;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WALL_COUNT:    wall_count_r <= cfg_data[6:0];
        CFG_PLAYER_RADIUS: radius_r     <= cfg_data[9:0];
        CFG_NEAR_DISTANCE: near_r       <= cfg_data;
        CFG_FAR_DISTANCE:  far_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic        in_acc;
  logic [5:0]  f_slot;
  logic [35:0] f_wall;
  logic [12:0] f_px, f_py;

  assign in_acc = in_tvalid && in_tready;
  assign f_slot = in_tdata[5:0];
  assign f_wall = in_tdata[41:6];
  assign f_px   = in_tdata[54:42];
  assign f_py   = in_tdata[67:55];

  // Wall table: {bottom, right, top, left}, whole units, registered read.
  logic [35:0] wall_mem [MaxWalls];
  logic [35:0] wall_rd_r;
  logic [CntW-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (in_acc && (mode_t'(in_tuser) == MODE_LOAD)) begin
      wall_mem[f_slot[IdxW-1:0]] <= f_wall;
    end
    wall_rd_r <= wall_mem[idx_r[IdxW-1:0]];
  end

  // Sequencer state.
  state_t      state_r, state_nxt;
  logic [12:0] px_r, px_nxt, py_r, py_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [19:0] radsq_r, radsq_nxt;
  logic [25:0] sqa_r, sqa_nxt;
  logic [26:0] best_r, best_nxt;
  logic        hit_r, hit_nxt;
  logic [13:0] d_r, d_nxt;
  logic [12:0] inv_r, inv_nxt;
  logic [24:0] sq_r, sq_nxt;
  logic [7:0]  vib_r, vib_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  // Shared iterative unit.
  iter_ctl_t   it_ctl;
  iter_sts_t   it_sts;
  logic [27:0] it_arg;
  logic [13:0] it_den;
  logic [13:0] it_res;

  crpe_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (it_ctl),
    .arg   (it_arg),
    .den   (it_den),
    .sts   (it_sts),
    .res   (it_res)
  );

  // Wall corners in Q9.4.
  logic [12:0] wl, wt, wr, wb;
  assign wl = {wall_rd_r[8:0],   {FracBits{1'b0}}};
  assign wt = {wall_rd_r[17:9],  {FracBits{1'b0}}};
  assign wr = {wall_rd_r[26:18], {FracBits{1'b0}}};
  assign wb = {wall_rd_r[35:27], {FracBits{1'b0}}};

  // Edge k: along-axis point coordinate pa against span a0..a1, cross
  // coordinate pb against the edge line bc.
  logic [12:0] pa, pb, a0, a1, bc, lo, hi, da, db;
  logic [25:0] sqb;
  logic [26:0] e_sum;
  logic        pt_in_wall;

  always_comb begin
    case (k_r)
      2'd0:    begin pa = px_r; pb = py_r; a0 = wl; a1 = wr; bc = wt; end
      2'd1:    begin pa = py_r; pb = px_r; a0 = wt; a1 = wb; bc = wr; end
      2'd2:    begin pa = px_r; pb = py_r; a0 = wl; a1 = wr; bc = wb; end
      default: begin pa = py_r; pb = px_r; a0 = wt; a1 = wb; bc = wl; end
    endcase
    lo = (a0 < a1) ? a0 : a1;
    hi = (a0 < a1) ? a1 : a0;
    if (pa < lo) begin
      da = lo - pa;
    end else if (pa > hi) begin
      da = pa - hi;
    end else begin
      da = '0;
    end
    db         = (pb >= bc) ? (pb - bc) : (bc - pb);
    sqb        = db * db;
    e_sum      = {1'b0, sqa_r} + {1'b0, sqb};
    pt_in_wall = (px_r >= wl) && (px_r <= wr) && (py_r >= wt) && (py_r <= wb);
  end

  logic [CntW-1:0] n_walls;
  assign n_walls = (wall_count_r > 7'(MaxWalls)) ? CntW'(MaxWalls) : CntW'(wall_count_r);

  logic [13:0] span, excess;
  logic [32:0] vib_prod;
  assign span     = far_r - near_r;
  assign excess   = d_r - near_r;
  assign vib_prod = sq_r * VIB_FULL;

  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    radsq_nxt     = radsq_r;
    sqa_nxt       = sqa_r;
    best_nxt      = best_r;
    hit_nxt       = hit_r;
    d_nxt         = d_r;
    inv_nxt       = inv_r;
    sq_nxt        = sq_r;
    vib_nxt       = vib_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    it_ctl.start  = 1'b0;
    it_ctl.op     = OP_SQRT;
    it_arg        = {1'b0, best_r};
    it_den        = span;
    in_tready     = (state_r == S_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (mode_t'(in_tuser) == MODE_QUERY)) begin
          px_nxt    = f_px;
          py_nxt    = f_py;
          cnt_nxt   = n_walls;
          idx_nxt   = '0;
          k_nxt     = 2'd0;
          hit_nxt   = 1'b0;
          best_nxt  = '1;
          radsq_nxt = radius_r * radius_r;
          if (n_walls == '0) begin
            d_nxt     = DIST_MAX;
            state_nxt = S_VIB_SEL;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        k_nxt     = 2'd0;
        state_nxt = S_EDGE_A;
      end
      S_EDGE_A: begin
        sqa_nxt = da * da;
        if ((k_r == 2'd0) && pt_in_wall) begin
          hit_nxt = 1'b1;
        end
        state_nxt = S_EDGE_B;
      end
      S_EDGE_B: begin
        if (e_sum < {7'd0, radsq_r}) begin
          hit_nxt = 1'b1;
        end
        if (e_sum < best_r) begin
          best_nxt = e_sum;
        end
        if (k_r == 2'd3) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ((idx_r + 1'b1) == cnt_r) ? S_ROOT_GO : S_FETCH;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_EDGE_A;
        end
      end
      S_ROOT_GO: begin
        it_ctl.start = 1'b1;
        it_ctl.op    = OP_SQRT;
        state_nxt    = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (it_sts.done) begin
          d_nxt     = it_res;
          state_nxt = S_VIB_SEL;
        end
      end
      S_VIB_SEL: begin
        state_nxt = S_SQ1;
        if (d_r > far_r) begin
          inv_nxt = '0;
        end else if (far_r <= near_r) begin
          inv_nxt = (d_r > near_r) ? 13'd0 : RATIO_ONE;
        end else if (d_r <= near_r) begin
          inv_nxt = RATIO_ONE;
        end else begin
          it_ctl.start = 1'b1;
          it_ctl.op    = OP_DIV;
          it_arg       = {excess, 12'd0, 2'b00};
          state_nxt    = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (it_sts.done) begin
          inv_nxt   = (it_res > {1'b0, RATIO_ONE}) ? 13'd0 : (RATIO_ONE - it_res[12:0]);
          state_nxt = S_SQ1;
        end
      end
      S_SQ1: begin
        sq_nxt    = inv_r * inv_r;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        vib_nxt   = vib_prod[31:24];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold the finished result until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, vib_r, d_r, hit_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    radsq_r    <= radsq_nxt;
    sqa_r      <= sqa_nxt;
    best_r     <= best_nxt;
    hit_r      <= hit_nxt;
    d_r        <= d_nxt;
    inv_r      <= inv_nxt;
    sq_r       <= sq_nxt;
    vib_r      <= vib_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The shared unit only finishes while the sequencer waits on it.
  `CRPE_ASSERT(a_iter_done_waited, it_sts.done |-> (state_r == S_ROOT_WAIT || state_r == S_DIV_WAIT))
  // A result appears only out of the completion state.
  `CRPE_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE))
  // The table walk never reads past the clamped wall count.
  `CRPE_ASSERT(a_walk_in_range, (state_r == S_FETCH) |-> (idx_r < cnt_r))
  // The vibration level sent out never exceeds full intensity.
  `CRPE_ASSERT(a_vib_range, out_valid_r |-> (out_data_r[22:15] <= VIB_FULL))

endmodule
`default_nettype wire
